[sv/mta_pkg.sv]
// shared constants, types and tables for the mean triangulation angle block
package mta_pkg;

    localparam int MAX_POINTS = 65536;
    localparam int CAP_INT = (MAX_POINTS < 65536) ? MAX_POINTS : 65536;
    localparam logic [16:0] POINT_CAP = 17'(CAP_INT);

    localparam int NUM_REGS = 6;
    localparam logic [2:0] REG_C1_X = 3'd0;
    localparam logic [2:0] REG_C1_Y = 3'd1;
    localparam logic [2:0] REG_C1_Z = 3'd2;
    localparam logic [2:0] REG_C2_X = 3'd3;
    localparam logic [2:0] REG_C2_Y = 3'd4;
    localparam logic [2:0] REG_C2_Z = 3'd5;

    localparam int CORDIC_STEPS = 24;
    localparam logic [30:0] RAD_TO_DEG_Q24 = 31'd961263669;
    localparam logic [31:0] ANG_90_Q24 = 32'd1509949440;
    localparam logic [31:0] ANG_180_Q24 = 32'd3019898880;
    localparam logic [30:0] Q30_ONE = 31'h40000000;
    localparam logic [63:0] Q60_ONE = 64'h1000_0000_0000_0000;

    typedef struct packed {
        logic busy;
        logic done;
    } sqrt_stat_t;

    // cordic step angle in degrees q8.24
    function automatic logic [30:0] step_angle(input logic [4:0] i);
        logic [30:0] a;
        unique case (i)
            5'd0:    a = 31'd754974720;
            5'd1:    a = 31'd445687602;
            5'd2:    a = 31'd235489088;
            5'd3:    a = 31'd119537938;
            5'd4:    a = 31'd60000934;
            5'd5:    a = 31'd30029717;
            5'd6:    a = 31'd15018523;
            5'd7:    a = 31'd7509720;
            5'd8:    a = 31'd3754917;
            5'd9:    a = 31'd1877466;
            5'd10:   a = 31'd938734;
            default: a = RAD_TO_DEG_Q24 >> i;
        endcase
        return a;
    endfunction

endpackage

[sv/mean_triangulation_angle_top.sv]
// mean triangulation angle: ray angles of 3D points against two camera centres
// Points enter one at a time, while in_stall is low. Each point holds the input off from
// its acceptance until the ray normalisation, which shifts the rays one bit at a time, three
// passes through the shared two-bit-per-cycle square root unit, the 34-step cosine divider
// and the 24-step CORDIC are done. A point that coincides with a centre skips these steps.
// The point marked last adds the serial mean division; its result then waits until the
// output register can take it, and the block takes no new point until that result has been
// loaded there. Once the point count reaches its cap, further points are not summed.
module mean_triangulation_angle_top import mta_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic        last_point,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] mean_angle_deg,
    output logic [16:0] point_total,
    output logic        degenerate_seen
);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_NORM   = 4'd1;
    localparam logic [3:0] ST_MAC    = 4'd2;
    localparam logic [3:0] ST_SQRT_A = 4'd3;
    localparam logic [3:0] ST_SQRT_B = 4'd4;
    localparam logic [3:0] ST_DEN    = 4'd5;
    localparam logic [3:0] ST_DIV    = 4'd6;
    localparam logic [3:0] ST_COSSQ  = 4'd7;
    localparam logic [3:0] ST_SQRT_S = 4'd8;
    localparam logic [3:0] ST_CORDIC = 4'd9;
    localparam logic [3:0] ST_ANGLE  = 4'd10;
    localparam logic [3:0] ST_ACC    = 4'd11;
    localparam logic [3:0] ST_MEAN   = 4'd12;
    localparam logic [3:0] ST_OUT    = 4'd13;

    logic [3:0]  state_reg;
    logic [5:0]  step_reg;

    logic [31:0] centre_reg [NUM_REGS];
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    logic [31:0] mag_a_reg [3];
    logic [31:0] mag_b_reg [3];
    logic [2:0]  sgn_a_reg;
    logic [2:0]  sgn_b_reg;
    logic        last_reg;

    logic [63:0] mul_reg;
    logic [63:0] dot_reg;
    logic [63:0] sa_reg;
    logic [63:0] sb_reg;
    logic [63:0] rad_s_reg;
    logic [31:0] root_a_reg;
    logic [31:0] root_b_reg;
    logic [61:0] den_reg;
    logic [65:0] drem_reg;
    logic [33:0] q_reg;
    logic [33:0] x_reg;
    logic [33:0] y_reg;
    logic [33:0] z_reg;
    logic [23:0] deg_reg;

    logic [39:0] sum_reg;
    logic [16:0] cnt_reg;
    logic        flag_reg;
    logic [40:0] numq_reg;
    logic [16:0] mrem_reg;

    logic        out_valid_reg;
    logic [23:0] mean_reg;
    logic [16:0] total_reg;
    logic        degen_out_reg;

    // point minus centre, split into sign and magnitude
    logic [31:0] pt [3];
    logic [32:0] diff_a [3];
    logic [32:0] diff_b [3];
    logic [32:0] neg_a [3];
    logic [32:0] neg_b [3];
    logic [31:0] amag_c [3];
    logic [31:0] bmag_c [3];

    logic [31:0] max_a;
    logic [31:0] max_b;
    logic        ok_a;
    logic        ok_b;
    logic        big_a;
    logic        big_b;

    logic [31:0] op1;
    logic [31:0] op2;
    logic [63:0] prod_c;

    logic [63:0] num_c;
    logic [65:0] dsh_c;
    logic        div_ge;
    logic [65:0] div_r1;
    logic [30:0] cm_c;

    logic        sq_start;
    logic [63:0] sq_rad;
    logic [31:0] sq_root;
    sqrt_stat_t  sq_stat;

    logic [4:0]  ci;
    logic [33:0] xs_c;
    logic [33:0] ys_c;
    logic [33:0] st_c;
    logic [31:0] zc_c;
    logic [31:0] d_c;
    logic [32:0] rnd_c;

    logic [17:0] mtrial;
    logic        mge;
    logic [17:0] mdiff;

    logic        in_take;
    logic        out_load;

    function automatic logic [31:0] max3(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
        logic [31:0] m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

    function automatic logic [33:0] shr_trunc(input logic [33:0] v, input logic [4:0] s);
        logic [33:0] m;
        logic [33:0] r;
        m = v[33] ? (~v + 34'd1) : v;
        r = m >> s;
        return v[33] ? (~r + 34'd1) : r;
    endfunction

    function automatic logic [63:0] signed_term(input logic [63:0] p, input logic neg);
        return neg ? (~p + 64'd1) : p;
    endfunction

    // configuration port
    assign pready = 1'b1;
    assign reg_idx = paddr[4:2];
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (reg_idx < 3'(NUM_REGS)) ? centre_reg[reg_idx] : 32'd0;

    assign in_stall = (state_reg != ST_IDLE);
    assign in_take = in_valid && !in_stall;
    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || !out_stall);

    assign pt[0] = point_x;
    assign pt[1] = point_y;
    assign pt[2] = point_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff_a[i] = {pt[i][31], pt[i]} - {centre_reg[i][31], centre_reg[i]};
            diff_b[i] = {pt[i][31], pt[i]} - {centre_reg[i + 3][31], centre_reg[i + 3]};
            neg_a[i] = ~diff_a[i] + 33'd1;
            neg_b[i] = ~diff_b[i] + 33'd1;
            amag_c[i] = diff_a[i][32] ? neg_a[i][31:0] : diff_a[i][31:0];
            bmag_c[i] = diff_b[i][32] ? neg_b[i][31:0] : diff_b[i][31:0];
        end
    end

    // largest magnitude must land in [2^29, 2^30)
    assign max_a = max3(mag_a_reg[0], mag_a_reg[1], mag_a_reg[2]);
    assign max_b = max3(mag_b_reg[0], mag_b_reg[1], mag_b_reg[2]);
    assign ok_a = (max_a[31:29] == 3'b001);
    assign ok_b = (max_b[31:29] == 3'b001);
    assign big_a = |max_a[31:30];
    assign big_b = |max_b[31:30];

    // shared multiplier operands
    always_comb
    begin
        op1 = '0;
        op2 = '0;
        unique case (state_reg)
            ST_MAC:
            begin
                unique case (step_reg)
                    6'd0:    begin op1 = mag_a_reg[0]; op2 = mag_b_reg[0]; end
                    6'd1:    begin op1 = mag_a_reg[1]; op2 = mag_b_reg[1]; end
                    6'd2:    begin op1 = mag_a_reg[2]; op2 = mag_b_reg[2]; end
                    6'd3:    begin op1 = mag_a_reg[0]; op2 = mag_a_reg[0]; end
                    6'd4:    begin op1 = mag_a_reg[1]; op2 = mag_a_reg[1]; end
                    6'd5:    begin op1 = mag_a_reg[2]; op2 = mag_a_reg[2]; end
                    6'd6:    begin op1 = mag_b_reg[0]; op2 = mag_b_reg[0]; end
                    6'd7:    begin op1 = mag_b_reg[1]; op2 = mag_b_reg[1]; end
                    6'd8:    begin op1 = mag_b_reg[2]; op2 = mag_b_reg[2]; end
                    default: begin op1 = '0; op2 = '0; end
                endcase
            end
            ST_DEN:
            begin
                op1 = root_a_reg;
                op2 = root_b_reg;
            end
            ST_COSSQ:
            begin
                op1 = {1'b0, cm_c};
                op2 = {1'b0, cm_c};
            end
            default:
            begin
                op1 = '0;
                op2 = '0;
            end
        endcase
    end

    assign prod_c = op1 * op2;

    // cosine divider, quotient integer part below 16
    assign num_c = dot_reg[63] ? (~dot_reg + 64'd1) : dot_reg;
    assign dsh_c = {1'b0, den_reg, 3'b000};
    assign div_ge = (drem_reg >= dsh_c);
    assign div_r1 = div_ge ? (drem_reg - dsh_c) : drem_reg;
    assign cm_c = (q_reg > 34'(Q30_ONE)) ? Q30_ONE : q_reg[30:0];

    // square root unit shared by both norms and the sine
    assign sq_start = ((state_reg == ST_SQRT_A) || (state_reg == ST_SQRT_B) ||
                       (state_reg == ST_SQRT_S)) && (step_reg == 6'd0);

    always_comb
    begin
        unique case (state_reg)
            ST_SQRT_A: sq_rad = sa_reg;
            ST_SQRT_B: sq_rad = sb_reg;
            default:   sq_rad = rad_s_reg;
        endcase
    end

    mta_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .root     (sq_root),
        .stat     (sq_stat)
    );

    // cordic vectoring step
    assign ci = step_reg[4:0];
    assign xs_c = shr_trunc(x_reg, ci);
    assign ys_c = shr_trunc(y_reg, ci);
    assign st_c = {3'b000, step_angle(ci)};

    // clamp to [0, 90], mirror for an obtuse angle, round to q8.16
    assign zc_c = z_reg[33] ? 32'd0 :
                  ((z_reg[32:0] > {1'b0, ANG_90_Q24}) ? ANG_90_Q24 : z_reg[31:0]);
    assign d_c = dot_reg[63] ? (ANG_180_Q24 - zc_c) : zc_c;
    assign rnd_c = {1'b0, d_c} + 33'd128;

    // mean divider, one quotient bit per cycle
    assign mtrial = {mrem_reg, numq_reg[40]};
    assign mge = (mtrial >= {1'b0, cnt_reg});
    assign mdiff = mtrial - {1'b0, cnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
            sum_reg       <= '0;
            cnt_reg       <= '0;
            flag_reg      <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++)
            begin
                centre_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_wr && (reg_idx < 3'(NUM_REGS)))
            begin
                centre_reg[reg_idx] <= pwdata;
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_take)
                    begin
                        state_reg <= (cnt_reg < POINT_CAP) ? ST_NORM : ST_ACC;
                        step_reg  <= '0;
                    end
                end
                ST_NORM:
                begin
                    if ((max_a == 32'd0) || (max_b == 32'd0))
                    begin
                        flag_reg  <= 1'b1;
                        state_reg <= ST_ACC;
                    end
                    else if (ok_a && ok_b)
                    begin
                        state_reg <= ST_MAC;
                        step_reg  <= '0;
                    end
                end
                ST_MAC:
                begin
                    if (step_reg == 6'd9)
                    begin
                        state_reg <= ST_SQRT_A;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_SQRT_A, ST_SQRT_B, ST_SQRT_S:
                begin
                    if (step_reg == 6'd0)
                    begin
                        step_reg <= 6'd1;
                    end
                    else if (sq_stat.done)
                    begin
                        step_reg <= '0;
                        unique case (state_reg)
                            ST_SQRT_A: state_reg <= ST_SQRT_B;
                            ST_SQRT_B: state_reg <= ST_DEN;
                            default:   state_reg <= ST_CORDIC;
                        endcase
                    end
                end
                ST_DEN:
                begin
                    if (step_reg == 6'd1)
                    begin
                        state_reg <= ST_DIV;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_DIV:
                begin
                    if (step_reg == 6'd33)
                    begin
                        state_reg <= ST_COSSQ;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_COSSQ:
                begin
                    if (step_reg == 6'd1)
                    begin
                        state_reg <= ST_SQRT_S;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_CORDIC:
                begin
                    if (step_reg == 6'(CORDIC_STEPS - 1))
                    begin
                        state_reg <= ST_ANGLE;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_ANGLE:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (cnt_reg < POINT_CAP)
                    begin
                        sum_reg <= sum_reg + {16'd0, deg_reg};
                        cnt_reg <= cnt_reg + 17'd1;
                    end
                    state_reg <= last_reg ? ST_MEAN : ST_IDLE;
                    step_reg  <= '0;
                end
                ST_MEAN:
                begin
                    if (step_reg == 6'd41)
                    begin
                        state_reg <= ST_OUT;
                        step_reg  <= '0;
                    end
                    else
                    begin
                        step_reg <= step_reg + 6'd1;
                    end
                end
                ST_OUT:
                begin
                    if (out_load)
                    begin
                        sum_reg       <= '0;
                        cnt_reg       <= '0;
                        flag_reg      <= 1'b0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                    step_reg  <= '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        mul_reg <= prod_c;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        mag_a_reg[i] <= amag_c[i];
                        mag_b_reg[i] <= bmag_c[i];
                        sgn_a_reg[i] <= diff_a[i][32];
                        sgn_b_reg[i] <= diff_b[i][32];
                    end
                    last_reg <= last_point;
                end
            end
            ST_NORM:
            begin
                deg_reg <= '0;
                dot_reg <= '0;
                sa_reg  <= '0;
                sb_reg  <= '0;
                for (int i = 0; i < 3; i++)
                begin
                    if (!ok_a)
                    begin
                        mag_a_reg[i] <= big_a ? (mag_a_reg[i] >> 1) : (mag_a_reg[i] << 1);
                    end
                    if (!ok_b)
                    begin
                        mag_b_reg[i] <= big_b ? (mag_b_reg[i] >> 1) : (mag_b_reg[i] << 1);
                    end
                end
            end
            ST_MAC:
            begin
                // product of the previous step arrives now
                unique case (step_reg)
                    6'd1:    dot_reg <= dot_reg + signed_term(mul_reg, sgn_a_reg[0] ^ sgn_b_reg[0]);
                    6'd2:    dot_reg <= dot_reg + signed_term(mul_reg, sgn_a_reg[1] ^ sgn_b_reg[1]);
                    6'd3:    dot_reg <= dot_reg + signed_term(mul_reg, sgn_a_reg[2] ^ sgn_b_reg[2]);
                    6'd4, 6'd5, 6'd6: sa_reg <= sa_reg + mul_reg;
                    6'd7, 6'd8, 6'd9: sb_reg <= sb_reg + mul_reg;
                    default: dot_reg <= dot_reg;
                endcase
            end
            ST_SQRT_A:
            begin
                if (sq_stat.done)
                begin
                    root_a_reg <= sq_root;
                end
            end
            ST_SQRT_B:
            begin
                if (sq_stat.done)
                begin
                    root_b_reg <= sq_root;
                end
            end
            ST_DEN:
            begin
                if (step_reg == 6'd1)
                begin
                    den_reg  <= mul_reg[61:0];
                    drem_reg <= {2'b00, num_c};
                    q_reg    <= '0;
                end
            end
            ST_DIV:
            begin
                drem_reg <= {div_r1[64:0], 1'b0};
                q_reg    <= {q_reg[32:0], div_ge};
            end
            ST_COSSQ:
            begin
                if (step_reg == 6'd1)
                begin
                    rad_s_reg <= Q60_ONE - mul_reg;
                end
            end
            ST_SQRT_S:
            begin
                if (sq_stat.done)
                begin
                    x_reg <= {3'b000, cm_c};
                    y_reg <= {2'b00, sq_root};
                    z_reg <= '0;
                end
            end
            ST_CORDIC:
            begin
                if (!y_reg[33])
                begin
                    x_reg <= x_reg + ys_c;
                    y_reg <= y_reg - xs_c;
                    z_reg <= z_reg + st_c;
                end
                else
                begin
                    x_reg <= x_reg - ys_c;
                    y_reg <= y_reg + xs_c;
                    z_reg <= z_reg - st_c;
                end
            end
            ST_ANGLE:
            begin
                deg_reg <= rnd_c[31:8];
            end
            ST_MEAN:
            begin
                if (step_reg == 6'd0)
                begin
                    numq_reg <= {1'b0, sum_reg} + {25'd0, cnt_reg[16:1]};
                    mrem_reg <= '0;
                end
                else
                begin
                    mrem_reg <= mge ? mdiff[16:0] : mtrial[16:0];
                    numq_reg <= {numq_reg[39:0], mge};
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    mean_reg      <= (cnt_reg == 17'd0) ? 24'd0 : numq_reg[23:0];
                    total_reg     <= cnt_reg;
                    degen_out_reg <= flag_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign mean_angle_deg = mean_reg;
    assign point_total = total_reg;
    assign degenerate_seen = degen_out_reg;

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= POINT_CAP)
        else $error("point count passed its cap");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_OUT))
        else $error("result raised outside the output state");

    assert property (@(posedge clk) disable iff (!rst_n) sq_start |-> !sq_stat.busy)
        else $error("square root restarted while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MAC) |-> (ok_a && ok_b))
        else $error("ray products taken on unnormalised rays");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_OUT) && !out_load |=> (state_reg == ST_OUT) && (cnt_reg != 17'd0))
        else $error("set closed before its result was loaded");

endmodule

[sv/mta_isqrt.sv]
// iterative floor square root, two radicand bits per cycle
module mta_isqrt import mta_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic [31:0] root,
    output sqrt_stat_t  stat
);

    logic [63:0] rad_reg;
    logic [31:0] rem_reg;
    logic [31:0] root_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [33:0] rem_shift;
    logic [33:0] trial;
    logic        ge;
    logic [33:0] rem_next;

    assign rem_shift = {rem_reg, rad_reg[63:62]};
    assign trial = {root_reg, 2'b01};
    assign ge = (rem_shift >= trial);
    // the remainder stays below twice the root, so 32 bits hold it
    assign rem_next = ge ? (rem_shift - trial) : rem_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= rem_next[31:0];
            root_reg <= {root_reg[30:0], ge};
        end
    end

    assign root = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

[tb/sv/mta_checker.sv]
// checker for the mean triangulation angle block: predicts set means and compares results
`timescale 1ns / 100ps
module mta_checker import mta_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic signed [31:0] point_x,
    input  logic signed [31:0] point_y,
    input  logic signed [31:0] point_z,
    input  logic        last_point,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [23:0] mean_angle_deg,
    input  logic [16:0] point_total,
    input  logic        degenerate_seen,
    output int          fail_count,
    output int          pending_means,
    output int          means_seen,
    output int          degenerate_sets
);

    typedef struct packed {
        logic [23:0] mean;
        logic [16:0] total;
        logic        degen;
    } set_result_t;

    set_result_t  mean_queue[$];
    logic [31:0]  centre[NUM_REGS];
    logic [39:0]  sum_acc;
    logic [16:0]  count_acc;
    logic         degen_acc;

    assign pending_means = mean_queue.size();

    function automatic longint trunc_shift(longint v, int s);
        return v >= 0 ? longint'(longint'(v) >>> s) : -((-v) >>> s);
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'h4000_0000_0000_0000;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // scale a ray so that its largest magnitude sits in [2^29, 2^30)
    function automatic bit scale_ray(input longint ray[3], output longint sc[3]);
        longint unsigned mag[3], m;
        int lsh, rsh;
        m = 0;
        lsh = 0;
        rsh = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = ray[i] >= 0 ? ray[i] : -ray[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 0;
        while ((m >> rsh) >= 64'h4000_0000) rsh++;
        while (rsh == 0 && (m << lsh) < 64'h2000_0000) lsh++;
        for (int i = 0; i < 3; i++)
        begin
            sc[i] = (mag[i] >> rsh) << lsh;
            if (ray[i] < 0) sc[i] = -sc[i];
        end
        return 1;
    endfunction

    function automatic bit ray_angle_q16(input longint ra[3], input longint rb[3],
                                         output longint unsigned deg);
        longint na[3], nb[3], dot, x, y, z, d, xs, ys, stp;
        longint unsigned sa, sb, den, num, q, rem, cm, sn;
        dot = 0;
        sa = 0;
        sb = 0;
        z = 0;
        if (!scale_ray(ra, na) || !scale_ray(rb, nb)) return 0;
        for (int i = 0; i < 3; i++)
        begin
            dot += na[i] * nb[i];
            sa += na[i] * na[i];
            sb += nb[i] * nb[i];
        end
        den = floor_sqrt(sa) * floor_sqrt(sb);
        num = dot >= 0 ? dot : -dot;
        q = num / den;
        rem = num % den;
        for (int i = 0; i < 30; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem -= den;
                q |= 1;
            end
        end
        cm = q > 64'h4000_0000 ? 64'h4000_0000 : q;
        sn = floor_sqrt(64'h1000_0000_0000_0000 - cm * cm);
        x = cm;
        y = sn;
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            case (i)
                0: stp = 754974720;  1: stp = 445687602;  2: stp = 235489088;
                3: stp = 119537938;  4: stp = 60000934;   5: stp = 30029717;
                6: stp = 15018523;   7: stp = 7509720;    8: stp = 3754917;
                9: stp = 1877466;    10: stp = 938734;
                default: stp = 64'd961263669 >> i;
            endcase
            xs = trunc_shift(x, i);
            ys = trunc_shift(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += stp;
            end
            else
            begin
                x -= ys; y += xs; z -= stp;
            end
        end
        if (z < 0) z = 0;
        if (z > (longint'(90) << 24)) z = longint'(90) << 24;
        d = dot < 0 ? (longint'(180) << 24) - z : z;
        deg = (longint'(d) + 128) >> 8;
        return 1;
    endfunction

    task automatic accumulate_point(logic signed [31:0] px, logic signed [31:0] py,
                                    logic signed [31:0] pz, logic fin);
        longint p[3], ra[3], rb[3];
        longint unsigned deg, mean;
        set_result_t r;
        p[0] = px; p[1] = py; p[2] = pz;
        deg = 0;
        mean = 0;
        for (int i = 0; i < 3; i++)
        begin
            ra[i] = p[i] - longint'($signed(centre[i]));
            rb[i] = p[i] - longint'($signed(centre[3 + i]));
        end
        if (count_acc < POINT_CAP)
        begin
            if (!ray_angle_q16(ra, rb, deg))
            begin
                deg = 0;
                degen_acc = 1;
            end
            sum_acc = sum_acc + 40'(deg);
            count_acc = count_acc + 1;
        end
        if (fin)
        begin
            if (count_acc != 0) mean = (64'(sum_acc) + count_acc / 2) / count_acc;
            r.mean = mean[23:0];
            r.total = count_acc;
            r.degen = degen_acc;
            mean_queue.push_back(r);
            sum_acc = 0;
            count_acc = 0;
            degen_acc = 0;
        end
    endtask

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        fail_count++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        set_result_t e;
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++) centre[i] = '0;
            sum_acc = 0;
            count_acc = 0;
            degen_acc = 0;
            fail_count = 0;
            means_seen = 0;
            degenerate_sets = 0;
            mean_queue.delete();
        end
        else
        begin
            // a point taken at this edge still sees the old centres
            if (in_valid && !in_stall)
                accumulate_point(point_x, point_y, point_z, last_point);
            if (psel && penable && pwrite && pready && paddr[4:2] < NUM_REGS)
                centre[paddr[4:2]] = pwdata;
            if (out_valid && !out_stall)
            begin
                means_seen++;
                if (degenerate_seen) degenerate_sets++;
                if (mean_queue.size() == 0)
                    report_mismatch("unexpected result", 1, 0);
                else
                begin
                    e = mean_queue.pop_front();
                    if (mean_angle_deg !== e.mean)
                        report_mismatch("mean_angle_deg", mean_angle_deg, e.mean);
                    if (point_total !== e.total)
                        report_mismatch("point_total", point_total, e.total);
                    if (degenerate_seen !== e.degen)
                        report_mismatch("degenerate_seen", degenerate_seen, e.degen);
                end
            end
        end
    end

endmodule

[tb/sv/tb_top.sv]
// testbench top for the mean triangulation angle block: stimulus, stalls and verdict
`timescale 1ns / 100ps
module tb_top import mta_pkg::*;;

    logic        clk = 0;
    logic        rst_n = 0;
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid = 0;
    logic        in_stall;
    logic signed [31:0] point_x = '0, point_y = '0, point_z = '0;
    logic        last_point = 0;
    logic        out_valid;
    logic        out_stall = 0;
    logic [23:0] mean_angle_deg;
    logic [16:0] point_total;
    logic        degenerate_seen;
    int          fail_count, pending_means, means_seen, degenerate_sets;
    int          points_sent = 0;
    bit          hold_output = 0;
    bit          stall_free = 0;
    logic [31:0] centre_val[NUM_REGS];

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    mean_triangulation_angle_top DUT (.*);

    mta_checker u_checker (.*);

    task automatic write_centre(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1; pwrite <= 1; penable <= 0;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        centre_val[idx] = val;
    endtask

    task automatic load_centres(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
                                logic [31:0] c3, logic [31:0] c4, logic [31:0] c5);
        write_centre(REG_C1_X, c0); write_centre(REG_C1_Y, c1);
        write_centre(REG_C1_Z, c2); write_centre(REG_C2_X, c3);
        write_centre(REG_C2_Y, c4); write_centre(REG_C2_Z, c5);
    endtask

    task automatic send_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                              logic fin);
        @(posedge clk);
        in_valid <= 1;
        point_x <= px; point_y <= py; point_z <= pz; last_point <= fin;
        do @(posedge clk); while (in_stall);
        in_valid <= 0;
        points_sent++;
    endtask

    task automatic drain_results();
        while (pending_means != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h8000_0000 | $urandom_range(0, 3);
            2: return 32'h7FFF_FFFF - $urandom_range(0, 3);
            3: return centre_val[$urandom_range(0, NUM_REGS - 1)];
            default: return 32'($signed($urandom_range(0, 2000000)) - 1000000) <<< 4;
        endcase
    endfunction

    task automatic random_point(logic fin);
        int pick;
        logic [31:0] px, py, pz;
        pick = $urandom_range(0, 9);
        px = random_coord(); py = random_coord(); pz = random_coord();
        // sometimes coincide exactly with a centre
        if (pick == 0)
        begin
            px = centre_val[0]; py = centre_val[1]; pz = centre_val[2];
        end
        else if (pick == 1)
        begin
            px = centre_val[3]; py = centre_val[4]; pz = centre_val[5];
        end
        send_point(px, py, pz, fin);
    endtask

    // receiver stall pattern, with a long hold-off window on request
    always @(posedge clk)
    begin
        if (hold_output)
            out_stall <= 1;
        else if (stall_free)
            out_stall <= 0;
        else
            out_stall <= ($urandom_range(0, 3) == 0);
    end

    initial
    begin
        #50_000_000;
        $display("timeout");
        $display("[mean_triangulation_angle_top] ERROR");
        $finish;
    end

    initial
    begin
        int len;
        for (int i = 0; i < NUM_REGS; i++) centre_val[i] = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1;

        // directed: all-zero centres make the point at the origin degenerate
        send_point(32'h0001_0000, 0, 0, 1);
        send_point(0, 0, 0, 1);
        drain_results();
        load_centres(32'hFFFF_0000, 0, 0, 32'h0001_0000, 0, 0);
        send_point(0, 32'h0001_0000, 0, 1);
        send_point(32'h0002_0000, 0, 0, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0);
        send_point(32'hFFFF_0000, 0, 0, 0);
        send_point(0, 0, 0, 1);
        send_point(0, 0, 32'h0000_0001, 1);
        send_point(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F, 1);
        drain_results();
        load_centres(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 0, 0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
        send_point(0, 0, 0, 1);
        drain_results();

        // random sets, centre settings change between phases
        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                load_centres(0, 0, 0, 32'h0000_0001, 0, 0);
            else
                load_centres(random_coord(), random_coord(), random_coord(),
                             random_coord(), random_coord(), random_coord());
            stall_free = (phase == 2);
            for (int n = 0; n < 150; n++)
            begin
                if (n == 40 && phase == 1)
                begin
                    // hold results back while points keep coming
                    fork
                        begin
                            hold_output = 1;
                            repeat (3000) @(posedge clk);
                            hold_output = 0;
                        end
                    join_none
                end
                if ($urandom_range(0, 4) == 0)
                begin
                    len = $urandom_range(1, 40);
                    repeat (len) @(posedge clk);
                end
                random_point($urandom_range(0, 5) == 0 || n == 149);
            end
            // let every set close before touching the centres again
            drain_results();
        end

        drain_results();
        $display("sent %0d points, checked %0d set means (%0d with degenerate points)",
                 points_sent, means_seen, degenerate_sets);
        $display("centres rewritten across 8 settings including the signed extremes");
        if (fail_count == 0)
            $display("[mean_triangulation_angle_top] OK");
        else
            $display("[mean_triangulation_angle_top] ERROR");
        $finish;
    end

endmodule
